@@ design/pli_pkg.sv @@
// Package for the piecewise linear interpolator: table size, status and region
// codes, controller-to-datapath command and status types. No dependencies.
`default_nettype none
package pli_pkg;
  localparam int unsigned MAX_KNOTS = 64;
  localparam int unsigned KNOT_AW   = $clog2(MAX_KNOTS);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SPACE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RG_BELOW  = 2'd0,
    RG_INSIDE = 2'd1,
    RG_ABOVE  = 2'd2,
    RG_SINGLE = 2'd3
  } region_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_RDX    = 3'd2,
    OP_SETUP  = 3'd3,
    OP_MUL    = 3'd4,
    OP_DIVINI = 3'd5,
    OP_DIV    = 3'd6,
    OP_FINAL  = 3'd7
  } op_t;

  typedef struct packed {
    op_t  op;
    logic mul_hi;
  } cmd_t;

  typedef struct packed {
    logic rd_lt;
    logic rd_gt;
    logic dx_zero;
  } sts_t;
endpackage
`default_nettype wire

@@ design/pli_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module pli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/pli_datapath.sv @@
// Datapath: knot stores, compare of a stored x against the query, and a
// 32x32 multiplier with a bit-serial divider for the interpolation step.
// Depends on pli_pkg and pli_ram.
`default_nettype none
module pli_datapath (
  input  wire logic                         clk,
  input  wire pli_pkg::cmd_t                cmd,
  input  wire logic [pli_pkg::KNOT_AW-1:0]  waddr,
  input  wire logic [pli_pkg::KNOT_AW-1:0]  raddr,
  input  wire logic [31:0]                  wx,
  input  wire logic [31:0]                  wy,
  input  wire logic [31:0]                  qx,
  input  wire logic [30:0]                  min_spacing,
  output pli_pkg::sts_t                     sts,
  output logic                              space_bad,
  output logic [31:0]                       rd_y,
  output logic [31:0]                       interp_y
);
  import pli_pkg::*;

  logic [31:0] rx, ry;
  logic        we;
  logic signed [32:0] x1_r, y1_r, dx_r, dy_r, ox_r;
  logic [32:0] ma_r, mb_r, md_r;
  logic        neg_r;
  logic [65:0] prod_r;
  logic [65:0] quo_r;
  logic [33:0] rem_r;
  logic [32:0] sub_rem;
  logic [33:0] trial;
  logic signed [33:0] step;
  logic [63:0] pp;
  logic [34:0] mag;
  logic signed [36:0] sum;

  assign we = (cmd.op == OP_LOAD);

  pli_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_xram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rx));
  pli_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_yram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(ry));

  assign sts.rd_lt   = $signed(rx) < $signed(qx);
  assign sts.rd_gt   = $signed(rx) > $signed(qx);
  assign sts.dx_zero = (dx_r == '0);
  assign rd_y        = ry;

  // Spacing step against the stored x at the previous position (read first).
  assign step      = $signed({{2{wx[31]}}, wx}) - $signed({{2{rx[31]}}, rx});
  assign space_bad = step < $signed({3'b000, min_spacing});

  // Restoring divide, one quotient bit per cycle, numerator shifted in MSB first.
  assign trial   = {rem_r[32:0], prod_r[65]};
  assign sub_rem = trial[32:0] - md_r;

  assign pp  = ma_r[31:0] * (cmd.mul_hi ? {31'd0, mb_r[32]} : mb_r[31:0]);
  assign mag = (quo_r[65:35] != '0 || quo_r[34:0] > 35'h4_0000_0000) ?
               35'h4_0000_0000 : quo_r[34:0];
  assign sum = neg_r ? ({{4{y1_r[32]}}, y1_r} - $signed({2'b00, mag}))
                     : ({{4{y1_r[32]}}, y1_r} + $signed({2'b00, mag}));

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RDX: begin
        // Lower knot of the interval is read here; upper follows next.
        x1_r <= {rx[31], rx};
        y1_r <= {ry[31], ry};
      end
      OP_SETUP: begin
        dx_r  <= $signed({rx[31], rx}) - x1_r;
        dy_r  <= $signed({ry[31], ry}) - y1_r;
        ox_r  <= $signed({qx[31], qx}) - x1_r;
        y1_r  <= y1_r;
        prod_r <= '0;
      end
      OP_MUL: begin
        if (!cmd.mul_hi) begin
          ma_r  <= ox_r[32] ? 33'(-ox_r) : 33'(ox_r);
          mb_r  <= dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
          md_r  <= dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
          neg_r <= (ox_r[32] ^ dy_r[32]) ^ dx_r[32];
        end else begin
          prod_r <= 66'(pp) + {33'd0, (ma_r[32] ? mb_r : 33'd0)} ;
        end
      end
      OP_DIVINI: begin
        // prod_r holds the cross terms a_lo*b_hi + a_hi*b; add a_lo*b_lo.
        prod_r <= (prod_r << 32) + 66'(pp);
        rem_r  <= '0;
        quo_r  <= '0;
      end
      OP_DIV: begin
        if (trial[33] || trial[32:0] >= md_r) begin
          rem_r <= {1'b0, sub_rem};
          quo_r <= {quo_r[64:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[64:0], 1'b0};
        end
        prod_r <= {prod_r[64:0], 1'b0};
      end
      OP_FINAL: begin
        if (sum > 37'sh0_7FFF_FFFF)       interp_y <= 32'h7FFF_FFFF;
        else if (sum < -37'sh0_8000_0000) interp_y <= 32'h8000_0000;
        else                              interp_y <= sum[31:0];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ design/pli_ctrl.sv @@
// Controller: request decode, binary search sequencing and result hand-off.
// Depends on pli_pkg.
`default_nettype none
module pli_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic                         req_type,
  input  wire logic [5:0]                   knot_index,
  input  wire logic [6:0]                   knot_count,
  input  wire pli_pkg::sts_t                sts,
  input  wire logic                         space_bad,
  input  wire logic [31:0]                  rd_y,
  input  wire logic [31:0]                  interp_y,
  output pli_pkg::cmd_t                     cmd,
  output logic [pli_pkg::KNOT_AW-1:0]       raddr,
  output logic                              cap,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [31:0]                       out_y,
  output logic [1:0]                        out_status,
  output logic [1:0]                        out_region
);
  import pli_pkg::*;
  localparam int unsigned AW = $clog2(MAX_KNOTS);
  localparam int unsigned CW = $clog2(MAX_KNOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LDRD, S_LDCHK, S_Q0, S_Q1, S_QN, S_SRCH, S_SWAIT,
    S_LO, S_HI, S_SET, S_M0, S_M1, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t      state_r;
  logic [CW-1:0] n_r, lo_r, hi_r, mid;
  logic [6:0]  dcnt_r;
  logic [5:0]  idx_r;
  logic [CW-1:0] nclamp;

  assign nclamp = (knot_count > 7'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : CW'(knot_count);
  assign mid    = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign cap = in_tvalid && in_tready;

  always_comb begin
    cmd   = '{op: OP_NONE, mul_hi: 1'b0};
    raddr = '0;
    unique case (state_r)
      S_IDLE:  if (cap && !req_type) raddr = AW'(knot_index - 6'd1);
      S_LDRD:  raddr = AW'(idx_r - 6'd1);
      S_LDCHK: cmd.op = OP_LOAD;
      S_Q0:    raddr = '0;
      S_Q1:    raddr = AW'(n_r - CW'(1));
      S_SRCH:  raddr = AW'(mid);
      S_LO:    begin raddr = (lo_r == '0) ? '0 : AW'(lo_r - CW'(1)); end
      S_HI:    begin raddr = AW'(lo_r); cmd.op = OP_RDX; end
      S_SET:   begin raddr = AW'(lo_r); cmd.op = OP_SETUP; end
      S_M0:    cmd.op = OP_MUL;
      S_M1:    begin cmd.op = OP_MUL; cmd.mul_hi = 1'b1; end
      S_DIV:   cmd.op = (dcnt_r == 7'd0) ? OP_DIVINI : OP_DIV;
      S_FIN:   cmd.op = OP_FINAL;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
      dcnt_r     <= '0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (cap) begin
          idx_r <= knot_index;
          n_r   <= nclamp;
          if (!req_type) begin
            state_r <= S_LDRD;
          end else if (nclamp == '0) begin
            out_y <= '0; out_status <= ST_EMPTY; out_region <= RG_BELOW;
            out_tvalid <= 1'b1;
          end else state_r <= S_Q0;
        end
        S_LDRD: state_r <= S_LDCHK;
        S_LDCHK: begin
          // Write happens this cycle; previous x is on the read port.
          out_y <= '0; out_region <= RG_BELOW;
          out_status <= (idx_r != 6'd0 && space_bad) ? ST_SPACE : ST_OK;
          out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_Q0: state_r <= S_Q1;
        S_Q1: begin
          // Data of knot 0 is valid now.
          out_status <= ST_OK;
          if (n_r == CW'(1)) begin
            out_y <= rd_y; out_region <= RG_SINGLE; out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end else if (sts.rd_gt) begin
            out_y <= rd_y; out_region <= RG_BELOW; out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end else state_r <= S_QN;
        end
        S_QN: begin
          if (sts.rd_lt) begin
            out_y <= rd_y; out_region <= RG_ABOVE; out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            lo_r <= '0; hi_r <= n_r; state_r <= S_SRCH;
          end
        end
        S_SRCH: state_r <= (lo_r < hi_r) ? S_SWAIT : S_LO;
        S_SWAIT: begin
          if (sts.rd_lt) lo_r <= mid + CW'(1);
          else           hi_r <= mid;
          state_r <= S_SRCH;
        end
        S_LO: begin
          out_region <= RG_INSIDE;
          state_r <= S_HI;
        end
        S_HI: begin
          if (lo_r == '0) begin
            // The query sits on the first knot, whose y is on the read port.
            out_y <= rd_y; out_status <= ST_OK; out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end else state_r <= S_SET;
        end
        S_SET: state_r <= S_M0;
        S_M0: begin
          if (sts.dx_zero) begin
            out_y <= rd_y; out_status <= ST_OK; out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end else state_r <= S_M1;
        end
        S_M1: begin dcnt_r <= '0; state_r <= S_DIV; end
        S_DIV: begin
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'd66) state_r <= S_FIN;
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: begin
          out_y <= interp_y; out_status <= ST_OK; out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_status != ST_RSVD) else $error("bad status");
endmodule
`default_nettype wire

@@ design/piecewise_linear_interpolator_unit.sv @@
// Piecewise linear interpolator, top level.
// Input channel (in_*): one transaction per load or query; tdata holds
// knot_index, knot_x, knot_y, query_x from the lowest bit, tuser holds req_type.
// Result channel (out_*): one transaction per input; tdata holds result_y,
// status, region from the lowest bit.
// Configuration: cfg_we with cfg_addr 0 = knot_count, 1 = min_spacing, only
// while idle.
// Loads go through the knot RAM read/write ports. A query on an empty table
// is answered on capture, a clamped query after the end knots are read, and
// an interpolated query after a binary search, each step of which waits on
// the single registered RAM read port, and a divide that yields 66 quotient bits.
// One item is in work at a time; in_tready is low while busy or while a
// result waits. A stalled receiver holds out_tvalid and the data stable.
// Reset clears the controller and the registers (knot_count 0, min_spacing 1);
// knot storage is not cleared and must be loaded before it is queried.
`default_nettype none
module piecewise_linear_interpolator_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [103:0]  in_tdata,  // knot_index, knot_x, knot_y, query_x
  input  wire logic          in_tuser,  // req_type
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [39:0]        out_tdata, // result_y, status, region
  input  wire logic          cfg_we,
  input  wire logic [0:0]    cfg_addr,
  input  wire logic [30:0]   cfg_wdata
);
  import pli_pkg::*;
  localparam logic [0:0] REG_COUNT = 1'b0;
  localparam logic [0:0] REG_SPACE = 1'b1;

  logic [6:0]  knot_count_r;
  logic [30:0] min_spacing_r;
  logic [5:0]  idx_r;
  logic [31:0] kx_r, ky_r, qx_r;
  cmd_t        cmd;
  sts_t        sts;
  logic        space_bad, cap;
  logic [31:0] rd_y, interp_y, out_y;
  logic [1:0]  out_status, out_region;
  logic [KNOT_AW-1:0] raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r  <= 7'd0;
      min_spacing_r <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COUNT: knot_count_r  <= cfg_wdata[6:0];
        REG_SPACE: min_spacing_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      idx_r <= in_tdata[5:0];
      kx_r  <= in_tdata[37:6];
      ky_r  <= in_tdata[69:38];
      qx_r  <= in_tdata[101:70];
    end
  end

  pli_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .req_type(in_tuser), .knot_index(in_tdata[5:0]), .knot_count(knot_count_r),
    .sts(sts), .space_bad(space_bad), .rd_y(rd_y), .interp_y(interp_y),
    .cmd(cmd), .raddr(raddr), .cap(cap), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_y(out_y), .out_status(out_status),
    .out_region(out_region));

  pli_datapath u_dp (
    .clk(clk), .cmd(cmd), .waddr(idx_r), .raddr(raddr),
    .wx(kx_r), .wy(ky_r), .qx(qx_r), .min_spacing(min_spacing_r),
    .sts(sts), .space_bad(space_bad), .rd_y(rd_y), .interp_y(interp_y));

  assign out_tdata = {4'd0, out_region, out_status, out_y};
endmodule
`default_nettype wire
